[src/mbrf_pkg.sv]
package mbrf_pkg;

    localparam int IDX_W   = 16;
    localparam int SIZE_W  = 4;
    localparam int DATA_W  = 8;
    localparam int FILL_W  = 9;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef struct packed {
        op_t                opcode;
        logic [1:0]         port;
        logic [DATA_W-1:0]  write_data;
        logic [SIZE_W-1:0]  size_log2;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               ok;
        logic [FILL_W-1:0]  fill_level;
    } rsp_t;

    // One entry of the per-port state memory
    typedef struct packed {
        logic [IDX_W-1:0]   wr_idx;
        logic [IDX_W-1:0]   rd_idx;
        logic [SIZE_W-1:0]  size_log2;
    } port_state_t;

endpackage

[src/mbrf_state_ram.sv]
module mbrf_state_ram #(
    parameter int NUM_PORTS     = 4,
    parameter int PORT_W        = 2,
    parameter int MAX_SIZE_LOG2 = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [PORT_W-1:0]    rd_addr,
    output mbrf_pkg::port_state_t rd_data,
    input  logic                 wr_en,
    input  logic [PORT_W-1:0]    wr_addr,
    input  mbrf_pkg::port_state_t wr_data
);

    mbrf_pkg::port_state_t state_mem [0:NUM_PORTS-1];
    mbrf_pkg::port_state_t rd_data_reg;
    logic [NUM_PORTS-1:0]  valid_reg;
    logic                  rd_valid_reg;
    mbrf_pkg::port_state_t reset_entry;

    assign reset_entry = '{wr_idx: '0, rd_idx: '0,
                           size_log2: mbrf_pkg::SIZE_W'(MAX_SIZE_LOG2)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= state_mem[rd_addr];
        end
    end

    // An entry never written reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : reset_entry;

endmodule

[src/mbrf_byte_ram.sv]
module mbrf_byte_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] byte_mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= byte_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/multi_port_byte_ring_fifo.sv]
// Byte FIFOs for NUM_PORTS ports sharing one byte store, each port a power-of-two
// ring of up to 2^MAX_SIZE_LOG2 bytes with free-running 16-bit indices. Issue one
// operation (init, write, read, flush) with start while busy is low; its result
// appears on result for exactly one cycle with done high and cannot be held off,
// so sample it then. An operation reads the port's index entry from the state
// memory and acts on it in S_LOOK; a read that returns a byte then waits in
// S_FETCH for the byte store read. busy falls in the cycle that shows done, and
// a new start is taken in that same cycle.
module multi_port_byte_ring_fifo #(
    parameter int NUM_PORTS     = 4,
    parameter int MAX_SIZE_LOG2 = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mbrf_pkg::cmd_t  command,
    output logic            done,
    output mbrf_pkg::rsp_t  result
);

    localparam int PORT_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int STORE_D    = NUM_PORTS << MAX_SIZE_LOG2;
    localparam int BYTE_AW    = PORT_W + MAX_SIZE_LOG2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_FETCH
    } state_t;

    state_t                 state_reg;
    mbrf_pkg::cmd_t         cmd_reg;
    logic                   port_ok_reg;
    logic [8:0]             fill_reg;
    logic                   done_reg;
    mbrf_pkg::rsp_t         result_reg;

    logic                   accept;
    logic                   port_ok_in;
    mbrf_pkg::port_state_t  cur;
    mbrf_pkg::port_state_t  upd;
    logic [15:0]            fill_now;
    logic [15:0]            fill_upd;
    logic [15:0]            cap;
    logic [MAX_SIZE_LOG2-1:0] slot_mask;
    logic                   has_room;
    logic                   not_empty;
    logic                   op_ok;
    logic                   byte_wr;
    logic                   byte_rd;
    logic [BYTE_AW-1:0]     byte_wr_addr;
    logic [BYTE_AW-1:0]     byte_rd_addr;
    logic [7:0]             byte_rd_data;
    logic [3:0]             init_size;

    assign accept     = start && !busy;
    assign port_ok_in = ({3'b000, command.port} < 5'(NUM_PORTS));
    assign busy       = (state_reg != S_IDLE);

    mbrf_state_ram #(
        .NUM_PORTS     (NUM_PORTS),
        .PORT_W        (PORT_W),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && port_ok_in),
        .rd_addr (PORT_W'(command.port)),
        .rd_data (cur),
        .wr_en   ((state_reg == S_LOOK) && port_ok_reg),
        .wr_addr (PORT_W'(cmd_reg.port)),
        .wr_data (upd)
    );

    mbrf_byte_ram #(
        .DEPTH  (STORE_D),
        .ADDR_W (BYTE_AW)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr),
        .wr_addr (byte_wr_addr),
        .wr_data (cmd_reg.write_data),
        .rd_en   (byte_rd),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < MAX_SIZE_LOG2; i++)
        begin
            slot_mask[i] = (5'(i) < {1'b0, cur.size_log2});
        end
    end

    assign fill_now  = cur.wr_idx - cur.rd_idx;
    assign cap       = 16'(1) << cur.size_log2;
    assign has_room  = (fill_now < cap);
    assign not_empty = (fill_now != 16'd0);
    assign init_size = (cmd_reg.size_log2 > 4'(MAX_SIZE_LOG2)) ? 4'(MAX_SIZE_LOG2)
                                                               : cmd_reg.size_log2;

    assign byte_wr_addr = {PORT_W'(cmd_reg.port), cur.wr_idx[MAX_SIZE_LOG2-1:0] & slot_mask};
    assign byte_rd_addr = {PORT_W'(cmd_reg.port), cur.rd_idx[MAX_SIZE_LOG2-1:0] & slot_mask};

    // Modify the entry read for this beat
    always_comb
    begin
        upd   = cur;
        op_ok = 1'b0;
        unique case (cmd_reg.opcode)
            mbrf_pkg::OP_INIT:
            begin
                upd.size_log2 = init_size;
                upd.wr_idx    = '0;
                upd.rd_idx    = '0;
                op_ok         = 1'b1;
            end
            mbrf_pkg::OP_WRITE:
            begin
                if (has_room)
                begin
                    upd.wr_idx = cur.wr_idx + 16'd1;
                    op_ok      = 1'b1;
                end
            end
            mbrf_pkg::OP_READ:
            begin
                if (not_empty)
                begin
                    upd.rd_idx = cur.rd_idx + 16'd1;
                    op_ok      = 1'b1;
                end
            end
            mbrf_pkg::OP_FLUSH:
            begin
                upd.wr_idx = '0;
                upd.rd_idx = '0;
                op_ok      = 1'b1;
            end
        endcase
    end

    assign fill_upd = upd.wr_idx - upd.rd_idx;
    assign byte_wr  = (state_reg == S_LOOK) && port_ok_reg
                      && (cmd_reg.opcode == mbrf_pkg::OP_WRITE) && has_room;
    assign byte_rd  = (state_reg == S_LOOK) && port_ok_reg
                      && (cmd_reg.opcode == mbrf_pkg::OP_READ) && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            result_reg  <= '0;
            cmd_reg     <= '0;
            port_ok_reg <= 1'b0;
            fill_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg     <= command;
                        port_ok_reg <= port_ok_in;
                        state_reg   <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (byte_rd)
                    begin
                        // hold the fill level until the byte arrives
                        fill_reg  <= fill_upd[8:0];
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{read_data: 8'd0,
                                        ok:         op_ok && port_ok_reg,
                                        fill_level: port_ok_reg ? fill_upd[8:0] : 9'd0};
                        state_reg  <= S_IDLE;
                    end
                end
                S_FETCH:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= '{read_data: byte_rd_data, ok: 1'b1, fill_level: fill_reg};
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_LOOK) || ($past(state_reg) == S_FETCH))
        else $error("done without an operation in flight");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.read_data == 8'd0))
        else $error("failed beat carries read data");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((cmd_reg.opcode == mbrf_pkg::OP_INIT)
                  || (cmd_reg.opcode == mbrf_pkg::OP_FLUSH)))
        |-> (result.fill_level == 9'd0))
        else $error("init or flush left bytes in the port");

endmodule

[tb/multi_port_byte_ring_fifo_tb.sv]
`timescale 1ns / 1ps

module multi_port_byte_ring_fifo_tb;

    localparam int NUM_PORTS     = 4;
    localparam int MAX_SIZE_LOG2 = 8;
    localparam int OP_TOTAL      = 1900;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    mbrf_pkg::cmd_t command = '0;
    logic busy;
    logic done;
    mbrf_pkg::rsp_t result;

    mbrf_pkg::cmd_t op_queue[$];
    mbrf_pkg::rsp_t op_results_due[$];

    // Shadow of the port state and the byte store
    logic [mbrf_pkg::IDX_W-1:0]  wr_idx    [NUM_PORTS];
    logic [mbrf_pkg::IDX_W-1:0]  rd_idx    [NUM_PORTS];
    logic [mbrf_pkg::SIZE_W-1:0] ring_log2 [NUM_PORTS];
    logic [mbrf_pkg::DATA_W-1:0] byte_mirror [NUM_PORTS << MAX_SIZE_LOG2];

    int   gen_log2 [NUM_PORTS];
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    mbrf_pkg::rsp_t want_rsp;

    multi_port_byte_ring_fifo #(
        .NUM_PORTS     (NUM_PORTS),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic mbrf_pkg::rsp_t apply_fifo_op(input mbrf_pkg::cmd_t c);
        mbrf_pkg::rsp_t             r;
        int                         p;
        int                         cap;
        logic [mbrf_pkg::IDX_W-1:0] fill;
        logic [mbrf_pkg::IDX_W-1:0] mask;
        r    = '0;
        p    = c.port;
        // a port beyond the last one changes nothing and reports an empty failure
        if (p >= NUM_PORTS)
            return r;
        cap  = 1 << ring_log2[p];
        mask = mbrf_pkg::IDX_W'(cap - 1);
        fill = wr_idx[p] - rd_idx[p];
        case (c.opcode)
            mbrf_pkg::OP_INIT:
            begin
                // saturate an oversized request to the full region
                ring_log2[p] = (c.size_log2 > MAX_SIZE_LOG2)
                               ? mbrf_pkg::SIZE_W'(MAX_SIZE_LOG2) : c.size_log2;
                wr_idx[p] = '0;
                rd_idx[p] = '0;
                r.ok = 1'b1;
            end
            mbrf_pkg::OP_WRITE:
            begin
                if (fill < cap)
                begin
                    byte_mirror[(p << MAX_SIZE_LOG2) + int'(wr_idx[p] & mask)] = c.write_data;
                    wr_idx[p] = wr_idx[p] + 1'b1;
                    r.ok = 1'b1;
                end
            end
            mbrf_pkg::OP_READ:
            begin
                if (fill != 0)
                begin
                    r.read_data = byte_mirror[(p << MAX_SIZE_LOG2) + int'(rd_idx[p] & mask)];
                    rd_idx[p] = rd_idx[p] + 1'b1;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                wr_idx[p] = '0;
                rd_idx[p] = '0;
                r.ok = 1'b1;
            end
        endcase
        fill = wr_idx[p] - rd_idx[p];
        r.fill_level = fill[mbrf_pkg::FILL_W-1:0];
        return r;
    endfunction

    task automatic queue_op(input mbrf_pkg::op_t op, input int port, input int data,
                            input int size);
        mbrf_pkg::cmd_t c;
        c.opcode     = op;
        c.port       = 2'(port);
        c.write_data = 8'(data);
        c.size_log2  = 4'(size);
        op_queue.push_back(c);
        if (op == mbrf_pkg::OP_INIT)
            gen_log2[port] = (size > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size;
    endtask

    // Sender: bursts of random length, each preceded by a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            command <= '0;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                wr_idx[p]    = '0;
                rd_idx[p]    = '0;
                ring_log2[p] = mbrf_pkg::SIZE_W'(MAX_SIZE_LOG2);
            end
        end
        else
        begin
            if (start && !busy)
                op_results_due.push_back(apply_fifo_op(command));
            if (!start || !busy)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    start   <= 1'b1;
                    command <= op_queue.pop_front();
                    burst_left--;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (op_results_due.size() == 0)
            begin
                $error("unexpected beat: read_data=%0h ok=%0b fill_level=%0d",
                       result.read_data, result.ok, result.fill_level);
                mismatches++;
            end
            else
            begin
                want_rsp = op_results_due.pop_front();
                if (result.read_data !== want_rsp.read_data)
                begin
                    $error("read_data: expected %0h, got %0h", want_rsp.read_data,
                           result.read_data);
                    mismatches++;
                end
                if (result.ok !== want_rsp.ok)
                begin
                    $error("ok: expected %0b, got %0b", want_rsp.ok, result.ok);
                    mismatches++;
                end
                if (result.fill_level !== want_rsp.fill_level)
                begin
                    $error("fill_level: expected %0d, got %0d", want_rsp.fill_level,
                           result.fill_level);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("multi_port_byte_ring_fifo_tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int p;
        int pick;
        int cap;
        int n;

        for (int i = 0; i < NUM_PORTS; i++)
            gen_log2[i] = MAX_SIZE_LOG2;

        // Port 0 at its reset size, then drain past empty
        queue_op(mbrf_pkg::OP_WRITE, 0, 8'hFF, 4'hF);
        queue_op(mbrf_pkg::OP_WRITE, 0, 8'h00, 4'h0);
        queue_op(mbrf_pkg::OP_READ,  0, 8'h00, 4'h0);
        queue_op(mbrf_pkg::OP_READ,  0, 8'hFF, 4'hF);
        queue_op(mbrf_pkg::OP_READ,  0, 8'h00, 4'h0);
        // One-byte ring: second write dropped
        queue_op(mbrf_pkg::OP_INIT,  1, 8'hFF, 0);
        queue_op(mbrf_pkg::OP_WRITE, 1, 8'hA5, 0);
        queue_op(mbrf_pkg::OP_WRITE, 1, 8'h5A, 0);
        queue_op(mbrf_pkg::OP_READ,  1, 8'h00, 0);
        queue_op(mbrf_pkg::OP_READ,  1, 8'h00, 0);
        // Oversized and exact full-region init
        queue_op(mbrf_pkg::OP_INIT,  2, 8'h00, 15);
        queue_op(mbrf_pkg::OP_INIT,  2, 8'hFF, MAX_SIZE_LOG2);
        // Two-byte ring: fill, overflow, wrap
        queue_op(mbrf_pkg::OP_INIT,  3, 8'h00, 1);
        queue_op(mbrf_pkg::OP_WRITE, 3, 8'h11, 0);
        queue_op(mbrf_pkg::OP_WRITE, 3, 8'h22, 0);
        queue_op(mbrf_pkg::OP_WRITE, 3, 8'h33, 0);
        queue_op(mbrf_pkg::OP_READ,  3, 8'h00, 0);
        queue_op(mbrf_pkg::OP_WRITE, 3, 8'h44, 0);
        queue_op(mbrf_pkg::OP_READ,  3, 8'h00, 0);
        queue_op(mbrf_pkg::OP_READ,  3, 8'h00, 0);
        // Flush with data held, then read empty
        queue_op(mbrf_pkg::OP_WRITE, 2, 8'h3C, 0);
        queue_op(mbrf_pkg::OP_FLUSH, 2, 8'hFF, 15);
        queue_op(mbrf_pkg::OP_READ,  2, 8'h00, 0);
        queue_op(mbrf_pkg::OP_FLUSH, 0, 8'h00, 0);

        // Fill a full-region port to the brim and one past, then drain it
        queue_op(mbrf_pkg::OP_INIT, 3, $urandom, MAX_SIZE_LOG2);
        repeat ((1 << MAX_SIZE_LOG2) + 1)
            queue_op(mbrf_pkg::OP_WRITE, 3, $urandom, $urandom);
        repeat ((1 << MAX_SIZE_LOG2) + 1)
            queue_op(mbrf_pkg::OP_READ, 3, $urandom, $urandom);

        while (op_queue.size() < OP_TOTAL)
        begin
            p    = $urandom_range(0, NUM_PORTS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                queue_op(mbrf_pkg::OP_INIT, p, $urandom,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 4));
            end
            else if (pick < 7)
            begin
                queue_op(mbrf_pkg::OP_FLUSH, p, $urandom, $urandom);
            end
            else if (pick < 17)
            begin
                // write a run of up to min(capacity, 16) + 2 bytes, then read that many back and up to two more
                cap = 1 << gen_log2[p];
                n   = $urandom_range(1, ((cap < 16) ? cap : 16) + 2);
                repeat (n)
                    queue_op(mbrf_pkg::OP_WRITE, p, $urandom, $urandom);
                repeat (n + $urandom_range(0, 2))
                    queue_op(mbrf_pkg::OP_READ, p, $urandom, $urandom);
            end
            else if (pick < 58)
            begin
                queue_op(mbrf_pkg::OP_WRITE, p, $urandom, $urandom);
            end
            else
            begin
                queue_op(mbrf_pkg::OP_READ, p, $urandom, $urandom);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (op_queue.size() != 0 || start || op_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (op_results_due.size() != 0)
        begin
            $error("%0d results never arrived", op_results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("multi_port_byte_ring_fifo_tb passed");
        else
            $display("multi_port_byte_ring_fifo_tb failed");
        $finish;
    end

endmodule

[filelist.f]
src/mbrf_pkg.sv
src/mbrf_state_ram.sv
src/mbrf_byte_ram.sv
src/multi_port_byte_ring_fifo.sv
tb/multi_port_byte_ring_fifo_tb.sv
